>>> design/gpio_alarm_edge_monitor_top_assert.svh
// assertion macros shared by the alarm edge monitor modules
`ifndef GPIO_ALARM_EDGE_MONITOR_TOP_ASSERT_SVH
`define GPIO_ALARM_EDGE_MONITOR_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GAEM_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define GAEM_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/gaem_pkg.sv
// shared types, codes and reset values of the alarm edge monitor
`default_nettype none

package gaem_pkg;

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [2:0] REG_AC_FAIL_LEVEL      = 3'd0;
    localparam logic [2:0] REG_BATT_MISSING_LEVEL = 3'd1;
    localparam logic [2:0] REG_CONTACT_A_LEVEL    = 3'd2;
    localparam logic [2:0] REG_CONTACT_B_LEVEL    = 3'd3;
    localparam logic [2:0] REG_RESTORE_HOLD_POLLS = 3'd4;
    localparam logic [2:0] REG_UPS_PRESENT        = 3'd5;

    localparam logic [7:0] RESTORE_HOLD_RESET = 8'd30;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // gpio numbers
    localparam logic [3:0] PIN_LASER   = 4'd2;
    localparam logic [3:0] PIN_RESTORE = 4'd3;
    localparam logic [3:0] PIN_VOLT    = 4'd4;
    localparam logic [3:0] PIN_AC      = 4'd5;
    localparam logic [3:0] PIN_BATT    = 4'd7;
    localparam logic [3:0] PIN_CA      = 4'd8;
    localparam logic [3:0] PIN_CB      = 4'd9;

    // event codes
    localparam logic [3:0] EV_NONE        = 4'd0;
    localparam logic [3:0] EV_LASER_RAISE = 4'd1;
    localparam logic [3:0] EV_LASER_CLEAR = 4'd2;
    localparam logic [3:0] EV_VOLT_RAISE  = 4'd3;
    localparam logic [3:0] EV_VOLT_CLEAR  = 4'd4;
    localparam logic [3:0] EV_POWER_RAISE = 4'd5;
    localparam logic [3:0] EV_POWER_CLEAR = 4'd6;
    localparam logic [3:0] EV_BATT_RAISE  = 4'd7;
    localparam logic [3:0] EV_BATT_CLEAR  = 4'd8;
    localparam logic [3:0] EV_CA_RAISE    = 4'd9;
    localparam logic [3:0] EV_CA_CLEAR    = 4'd10;
    localparam logic [3:0] EV_CB_RAISE    = 4'd11;
    localparam logic [3:0] EV_CB_CLEAR    = 4'd12;
    localparam logic [3:0] EV_RESTORE     = 4'd13;

    // ups led commands
    localparam logic [1:0] LED_KEEP  = 2'd0;
    localparam logic [1:0] LED_OFF   = 2'd1;
    localparam logic [1:0] LED_ON    = 2'd2;
    localparam logic [1:0] LED_BLINK = 2'd3;

    // what a sampled pin is
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_LASER,
        KIND_RESTORE,
        KIND_VOLT,
        KIND_AC,
        KIND_BATT,
        KIND_CA,
        KIND_CB
    } kind_t;

    // classified beat: active means alarm level, or a low poll for restore
    typedef struct packed {
        kind_t kind;
        logic  active;
    } item_t;

    // configuration seen by front and back
    typedef struct packed {
        logic       ac_fail_level;
        logic       batt_missing_level;
        logic       contact_a_level;
        logic       contact_b_level;
        logic [7:0] restore_hold_polls;
        logic       ups_load;
        logic       ups_value;
    } cfg_t;

endpackage

`default_nettype wire

>>> design/gpio_alarm_edge_monitor_top.sv
// top level of the gpio alarm edge monitor
//
// Usage: feed one polled gpio sample per beat on s_t*; each beat yields
// exactly one result beat on m_t* carrying an event code (0 when nothing
// changed) and a ups led command. Raise/clear events are reported for
// laser-on, battery low voltage, ac power, battery missing and the two dry
// contacts; holding the restore button low for the configured number of
// polls gives a factory-restore event.
// An accepted sample is registered in the queue, then in the result register.
// Throughput: one beat per cycle sustained while m_tready stays high; the front
// end classifies the pin into a two-entry queue, the back end updates the flags
// and loads the result register.
// Stall: while m_tready is low the result register holds, the queue fills
// and s_tready drops once it is full; nothing is lost.
// Reset: aresetn low clears all flags, the restore counter, the queue and
// the output; registers return to their reset values and ups valid to 0.
// Configuration goes through the apb port and is to be written only while idle;
// the block does not enforce this; writing the ups present register also reloads the ups valid flag.
`default_nettype none

module gpio_alarm_edge_monitor_top #(
    parameter int QUEUE_DEPTH = gaem_pkg::QUEUE_DEPTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // apb configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [gaem_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [gaem_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [gaem_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    // sample input
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,  // pin_id[3:0], level[4], zero[7:5]
    // result output
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [7:0]                      m_tdata   // event_code[3:0], ups_led_mode[5:4], zero[7:6]
);

    gaem_pkg::cfg_t  cfg;
    gaem_pkg::item_t push_item;
    gaem_pkg::item_t head_item;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_valid;
    logic [3:0]      event_code;
    logic [1:0]      ups_led_mode;

    gaem_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gaem_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .pin_id   (s_tdata[3:0]),
        .level    (s_tdata[4]),
        .cfg      (cfg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    gaem_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (head_item)
    );

    gaem_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .event_code   (event_code),
        .ups_led_mode (ups_led_mode)
    );

    assign m_tdata = {2'b00, ups_led_mode, event_code};

endmodule

`default_nettype wire

>>> design/gaem_regs.sv
// apb configuration registers of the alarm edge monitor
`default_nettype none

module gaem_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [gaem_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [gaem_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [gaem_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output gaem_pkg::cfg_t                       cfg
);

    logic       ac_lvl_reg;
    logic       batt_lvl_reg;
    logic       ca_lvl_reg;
    logic       cb_lvl_reg;
    logic [7:0] hold_reg;
    logic       ups_present_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ac_lvl_reg      <= 1'b1;
            batt_lvl_reg    <= 1'b1;
            ca_lvl_reg      <= 1'b1;
            cb_lvl_reg      <= 1'b1;
            hold_reg        <= gaem_pkg::RESTORE_HOLD_RESET;
            ups_present_reg <= 1'b0;
        end else if (wr_en) begin
            unique case (idx)
                gaem_pkg::REG_AC_FAIL_LEVEL:      ac_lvl_reg      <= pwdata[0];
                gaem_pkg::REG_BATT_MISSING_LEVEL: batt_lvl_reg    <= pwdata[0];
                gaem_pkg::REG_CONTACT_A_LEVEL:    ca_lvl_reg      <= pwdata[0];
                gaem_pkg::REG_CONTACT_B_LEVEL:    cb_lvl_reg      <= pwdata[0];
                gaem_pkg::REG_RESTORE_HOLD_POLLS: hold_reg        <= pwdata[7:0];
                gaem_pkg::REG_UPS_PRESENT:        ups_present_reg <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (idx)
            gaem_pkg::REG_AC_FAIL_LEVEL:      prdata[0]   = ac_lvl_reg;
            gaem_pkg::REG_BATT_MISSING_LEVEL: prdata[0]   = batt_lvl_reg;
            gaem_pkg::REG_CONTACT_A_LEVEL:    prdata[0]   = ca_lvl_reg;
            gaem_pkg::REG_CONTACT_B_LEVEL:    prdata[0]   = cb_lvl_reg;
            gaem_pkg::REG_RESTORE_HOLD_POLLS: prdata[7:0] = hold_reg;
            gaem_pkg::REG_UPS_PRESENT:        prdata[0]   = ups_present_reg;
            default: begin
            end
        endcase
    end

    // boot detect write also reloads the ups valid flag
    assign cfg.ac_fail_level      = ac_lvl_reg;
    assign cfg.batt_missing_level = batt_lvl_reg;
    assign cfg.contact_a_level    = ca_lvl_reg;
    assign cfg.contact_b_level    = cb_lvl_reg;
    assign cfg.restore_hold_polls = hold_reg;
    assign cfg.ups_load           = wr_en && (idx == gaem_pkg::REG_UPS_PRESENT);
    assign cfg.ups_value          = pwdata[0];

endmodule

`default_nettype wire

>>> design/gaem_front.sv
// front end: takes sample beats and classifies them for the queue
`default_nettype none

module gaem_front (
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [3:0]     pin_id,
    input  wire logic           level,
    input  wire gaem_pkg::cfg_t cfg,
    input  wire logic           q_full,
    output logic                q_push,
    output gaem_pkg::item_t     q_item
);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    // pin decode and active-level compare
    always_comb begin
        q_item.kind   = gaem_pkg::KIND_NONE;
        q_item.active = 1'b0;
        unique case (pin_id)
            gaem_pkg::PIN_LASER: begin
                q_item.kind   = gaem_pkg::KIND_LASER;
                q_item.active = level;
            end
            gaem_pkg::PIN_RESTORE: begin
                q_item.kind   = gaem_pkg::KIND_RESTORE;
                q_item.active = !level;
            end
            gaem_pkg::PIN_VOLT: begin
                q_item.kind   = gaem_pkg::KIND_VOLT;
                q_item.active = level;
            end
            gaem_pkg::PIN_AC: begin
                q_item.kind   = gaem_pkg::KIND_AC;
                q_item.active = (level == cfg.ac_fail_level);
            end
            gaem_pkg::PIN_BATT: begin
                q_item.kind   = gaem_pkg::KIND_BATT;
                q_item.active = (level == cfg.batt_missing_level);
            end
            gaem_pkg::PIN_CA: begin
                q_item.kind   = gaem_pkg::KIND_CA;
                q_item.active = (level == cfg.contact_a_level);
            end
            gaem_pkg::PIN_CB: begin
                q_item.kind   = gaem_pkg::KIND_CB;
                q_item.active = (level == cfg.contact_b_level);
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/gaem_queue.sv
// short queue of classified beats between front and back
`default_nettype none

`include "gpio_alarm_edge_monitor_top_assert.svh"

module gaem_queue #(
    parameter int DEPTH = gaem_pkg::QUEUE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire gaem_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 valid,
    output gaem_pkg::item_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    gaem_pkg::item_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full  = (cnt_reg == FULL_CNT);
    assign valid = (cnt_reg != '0);
    assign head  = mem_reg[rptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

    // occupancy
    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wptr_reg <= (wptr_reg == LAST) ? '0 : wptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == LAST) ? '0 : rptr_reg + PTR_W'(1);
            end
        end
    end

    `GAEM_ASSERT_NOW(a_q_no_overflow, aclk, aresetn, push, !full || pop, "queue push while full")
    `GAEM_ASSERT_NOW(a_q_no_underflow, aclk, aresetn, pop, valid, "queue pop while empty")
    `GAEM_ASSERT_NOW(a_q_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= FULL_CNT, "queue count too big")

endmodule

`default_nettype wire

>>> design/gaem_back.sv
// back end: alarm flags, restore counter and the result register
`default_nettype none

`include "gpio_alarm_edge_monitor_top_assert.svh"

module gaem_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire gaem_pkg::cfg_t  cfg,
    input  wire logic            q_valid,
    input  wire gaem_pkg::item_t q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [3:0]           event_code,
    output logic [1:0]           ups_led_mode
);

    logic       laser_reg, laser_next;
    logic       volt_reg, volt_next;
    logic       ac_reg, ac_next;
    logic       batt_reg, batt_next;
    logic       ca_reg, ca_next;
    logic       cb_reg, cb_next;
    logic       ups_ok_reg, ups_ok_next;
    logic [7:0] hold_cnt_reg, hold_cnt_next;
    logic [7:0] hold_inc;
    logic       out_valid_reg;
    logic [3:0] ev_reg, ev_next;
    logic [1:0] led_reg, led_next;

    assign q_pop    = q_valid && (!out_valid_reg || m_tready);
    assign hold_inc = hold_cnt_reg + 8'd1;

    // edge detection on the head beat
    always_comb begin
        laser_next    = laser_reg;
        volt_next     = volt_reg;
        ac_next       = ac_reg;
        batt_next     = batt_reg;
        ca_next       = ca_reg;
        cb_next       = cb_reg;
        ups_ok_next   = ups_ok_reg;
        hold_cnt_next = hold_cnt_reg;
        ev_next       = gaem_pkg::EV_NONE;
        led_next      = gaem_pkg::LED_KEEP;
        unique case (q_item.kind)
            gaem_pkg::KIND_LASER: begin
                if (q_item.active != laser_reg) begin
                    laser_next = q_item.active;
                    ev_next    = q_item.active ? gaem_pkg::EV_LASER_RAISE
                                               : gaem_pkg::EV_LASER_CLEAR;
                end
            end
            gaem_pkg::KIND_RESTORE: begin
                if (q_item.active) begin
                    if (hold_inc >= cfg.restore_hold_polls) begin
                        ev_next       = gaem_pkg::EV_RESTORE;
                        hold_cnt_next = '0;
                    end else begin
                        hold_cnt_next = hold_inc;
                    end
                end else begin
                    hold_cnt_next = '0;
                end
            end
            gaem_pkg::KIND_VOLT: begin
                // ignored while the ups is not valid
                if (ups_ok_reg && (q_item.active != volt_reg)) begin
                    volt_next = q_item.active;
                    if (q_item.active) begin
                        ev_next  = gaem_pkg::EV_VOLT_RAISE;
                        led_next = gaem_pkg::LED_BLINK;
                    end else begin
                        ev_next  = gaem_pkg::EV_VOLT_CLEAR;
                        led_next = gaem_pkg::LED_ON;
                    end
                end
            end
            gaem_pkg::KIND_AC: begin
                if (q_item.active != ac_reg) begin
                    ac_next = q_item.active;
                    ev_next = q_item.active ? gaem_pkg::EV_POWER_RAISE
                                            : gaem_pkg::EV_POWER_CLEAR;
                end
            end
            gaem_pkg::KIND_BATT: begin
                // missing battery turns the ups off, its return revalidates it
                if (q_item.active != batt_reg) begin
                    batt_next   = q_item.active;
                    ups_ok_next = !q_item.active;
                    if (q_item.active) begin
                        ev_next  = gaem_pkg::EV_BATT_RAISE;
                        led_next = gaem_pkg::LED_OFF;
                    end else begin
                        ev_next  = gaem_pkg::EV_BATT_CLEAR;
                    end
                end
            end
            gaem_pkg::KIND_CA: begin
                if (q_item.active != ca_reg) begin
                    ca_next = q_item.active;
                    ev_next = q_item.active ? gaem_pkg::EV_CA_RAISE
                                            : gaem_pkg::EV_CA_CLEAR;
                end
            end
            gaem_pkg::KIND_CB: begin
                if (q_item.active != cb_reg) begin
                    cb_next = q_item.active;
                    ev_next = q_item.active ? gaem_pkg::EV_CB_RAISE
                                            : gaem_pkg::EV_CB_CLEAR;
                end
            end
            gaem_pkg::KIND_NONE: begin
            end
            default: begin
            end
        endcase
    end

    // state update on pop; the ups valid flag also reloads on a ups present write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            laser_reg    <= 1'b0;
            volt_reg     <= 1'b0;
            ac_reg       <= 1'b0;
            batt_reg     <= 1'b0;
            ca_reg       <= 1'b0;
            cb_reg       <= 1'b0;
            ups_ok_reg   <= 1'b0;
            hold_cnt_reg <= '0;
        end else begin
            if (q_pop) begin
                laser_reg    <= laser_next;
                volt_reg     <= volt_next;
                ac_reg       <= ac_next;
                batt_reg     <= batt_next;
                ca_reg       <= ca_next;
                cb_reg       <= cb_next;
                hold_cnt_reg <= hold_cnt_next;
            end
            if (cfg.ups_load) begin
                ups_ok_reg <= cfg.ups_value;
            end else if (q_pop) begin
                ups_ok_reg <= ups_ok_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ev_reg  <= ev_next;
            led_reg <= led_next;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign event_code   = ev_reg;
    assign ups_led_mode = led_reg;

    `GAEM_ASSERT_NEXT(a_restore_clears_cnt, aclk, aresetn,
        q_pop && (ev_next == gaem_pkg::EV_RESTORE), hold_cnt_reg == '0,
        "restore event left the hold count running")
    `GAEM_ASSERT_NEXT(a_batt_raise_drops_ups, aclk, aresetn,
        q_pop && !cfg.ups_load && (ev_next == gaem_pkg::EV_BATT_RAISE),
        !ups_ok_reg, "battery missing raise kept the ups valid")
    `GAEM_ASSERT_NOW(a_blink_only_volt, aclk, aresetn,
        out_valid_reg && (led_reg == gaem_pkg::LED_BLINK),
        ev_reg == gaem_pkg::EV_VOLT_RAISE, "fast blink without a volt-low raise")

endmodule

`default_nettype wire

>>> verif/gaem_checker.sv
// result checker for the gpio alarm edge monitor: tracks the flags and compares each result beat
module gaem_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic                            pready,
    input  wire logic [gaem_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [gaem_pkg::APB_DATA_W-1:0] pwdata,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [7:0]                      s_tdata,  // pin_id[3:0], level[4], zero[7:5]
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [7:0]                      m_tdata,  // event_code[3:0], ups_led_mode[5:4], zero[7:6]
    output int                                   mismatches,
    output int                                   awaiting
);
    import gaem_pkg::*;

    localparam int REPORT_CAP = 30;

    typedef struct packed {
        logic [3:0] event_code;
        logic [1:0] led_mode;
    } alarm_result_t;

    // configuration copy
    logic       ac_level;
    logic       batt_level;
    logic       ca_level;
    logic       cb_level;
    logic [7:0] hold_polls;

    // alarm state
    logic       laser_on;
    logic       volt_low;
    logic       ac_fail;
    logic       batt_missing;
    logic       contact_a;
    logic       contact_b;
    logic       ups_ok;
    logic [7:0] restore_count;

    alarm_result_t awaited_results[$];

    // one line per mismatch, printing stops after the cap but counting does not
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < REPORT_CAP)
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        mismatches = mismatches + 1;
    endtask

    // raise when the input turns active, clear when it goes inactive
    function automatic void flag_transition(input logic was, input logic active,
                                            input logic [3:0] raise_ev,
                                            input logic [3:0] clear_ev,
                                            output logic now, output logic [3:0] ev);
        now = active;
        if (active && !was)
            ev = raise_ev;
        else if (!active && was)
            ev = clear_ev;
        else
            ev = EV_NONE;
    endfunction

    // register write as seen on the apb port
    task automatic take_register(input logic [2:0] idx, input logic [APB_DATA_W-1:0] value);
        case (idx)
            REG_AC_FAIL_LEVEL:      ac_level   = value[0];
            REG_BATT_MISSING_LEVEL: batt_level = value[0];
            REG_CONTACT_A_LEVEL:    ca_level   = value[0];
            REG_CONTACT_B_LEVEL:    cb_level   = value[0];
            REG_RESTORE_HOLD_POLLS: hold_polls = value[7:0];
            // boot detection also reloads the ups valid flag
            REG_UPS_PRESENT:        ups_ok     = value[0];
            default: ;
        endcase
    endtask

    // alarm state update for one sample, returns the result it causes
    function automatic alarm_result_t predict_sample(input logic [3:0] pin, input logic lvl);
        alarm_result_t res;
        res.event_code = EV_NONE;
        res.led_mode   = LED_KEEP;
        case (pin)
            PIN_LASER:
                flag_transition(laser_on, lvl, EV_LASER_RAISE, EV_LASER_CLEAR,
                                laser_on, res.event_code);
            PIN_RESTORE: begin
                // low polls count up, a high poll starts over
                if (!lvl) begin
                    restore_count = restore_count + 8'd1;
                    if (restore_count >= hold_polls) begin
                        res.event_code = EV_RESTORE;
                        restore_count  = '0;
                    end
                end else begin
                    restore_count = '0;
                end
            end
            PIN_VOLT: begin
                // ignored while the ups is not valid
                if (ups_ok) begin
                    flag_transition(volt_low, lvl, EV_VOLT_RAISE, EV_VOLT_CLEAR,
                                    volt_low, res.event_code);
                    if (res.event_code == EV_VOLT_RAISE)
                        res.led_mode = LED_BLINK;
                    else if (res.event_code == EV_VOLT_CLEAR)
                        res.led_mode = LED_ON;
                end
            end
            PIN_AC:
                flag_transition(ac_fail, lvl == ac_level, EV_POWER_RAISE, EV_POWER_CLEAR,
                                ac_fail, res.event_code);
            PIN_BATT: begin
                flag_transition(batt_missing, lvl == batt_level, EV_BATT_RAISE, EV_BATT_CLEAR,
                                batt_missing, res.event_code);
                if (res.event_code == EV_BATT_RAISE) begin
                    res.led_mode = LED_OFF;
                    ups_ok       = 1'b0;
                end else if (res.event_code == EV_BATT_CLEAR) begin
                    ups_ok = 1'b1;
                end
            end
            PIN_CA:
                flag_transition(contact_a, lvl == ca_level, EV_CA_RAISE, EV_CA_CLEAR,
                                contact_a, res.event_code);
            PIN_CB:
                flag_transition(contact_b, lvl == cb_level, EV_CB_RAISE, EV_CB_CLEAR,
                                contact_b, res.event_code);
            default: ;
        endcase
        return res;
    endfunction

    // watch config, result and sample channels at each edge
    always @(posedge aclk) begin
        alarm_result_t want;
        if (!aresetn) begin
            ac_level      = 1'b1;
            batt_level    = 1'b1;
            ca_level      = 1'b1;
            cb_level      = 1'b1;
            hold_polls    = RESTORE_HOLD_RESET;
            laser_on      = 1'b0;
            volt_low      = 1'b0;
            ac_fail       = 1'b0;
            batt_missing  = 1'b0;
            contact_a     = 1'b0;
            contact_b     = 1'b0;
            ups_ok        = 1'b0;
            restore_count = '0;
            awaited_results.delete();
            mismatches = 0;
            awaiting <= 0;
        end else begin
            if (psel && penable && pwrite && pready)
                take_register(paddr[APB_ADDR_W-1:2], pwdata);
            // results are compared before this edge's sample is predicted
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result beat with nothing awaited", m_tdata, 8'h00);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tdata[3:0] !== want.event_code)
                        report_mismatch("event_code", {4'h0, m_tdata[3:0]},
                                        {4'h0, want.event_code});
                    if (m_tdata[5:4] !== want.led_mode)
                        report_mismatch("ups_led_mode", {6'h00, m_tdata[5:4]},
                                        {6'h00, want.led_mode});
                    if (m_tdata[7:6] !== 2'b00)
                        report_mismatch("result padding", {6'h00, m_tdata[7:6]}, 8'h00);
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(predict_sample(s_tdata[3:0], s_tdata[4]));
            awaiting <= awaited_results.size();
        end
    end

endmodule

>>> verif/tb.sv
// testbench top for the gpio alarm edge monitor: sample stimulus, apb setup, stalls, verdict
module tb;
    import gaem_pkg::*;

    localparam int HOLD_OFF_CYCLES = 60;
    localparam int SETTLE_CYCLES   = 8;
    localparam int LIMIT_CYCLES    = 400000;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // pin_id[3:0], level[4], zero[7:5]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;   // event_code[3:0], ups_led_mode[5:4], zero[7:6]

    int send_idle_pct;
    int recv_idle_pct;
    int holds_asked;
    int holds_done;
    int mismatches;
    int awaiting;

    gpio_alarm_edge_monitor_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    gaem_checker watch (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #(4 * LIMIT_CYCLES);
        $display("gpio_alarm_edge_monitor_top: mismatch");
        $finish;
    end

    // result side: random backpressure, or a long hold-off when asked
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_done != holds_asked) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                holds_done = holds_done + 1;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // one sample beat, with random idle cycles ahead of it
    task automatic send_sample(input logic [3:0] pin, input logic lvl);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, lvl, pin};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaiting != 0);
    endtask

    // setup and access cycle; psel stays up so writes can follow back to back
    task automatic apb_write(input logic [2:0] idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    // write every register once the block is idle
    task automatic configure(input logic ac, input logic batt, input logic ca, input logic cb,
                             input logic [7:0] hold, input logic ups);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        apb_write(REG_AC_FAIL_LEVEL, {31'd0, ac});
        apb_write(REG_BATT_MISSING_LEVEL, {31'd0, batt});
        apb_write(REG_CONTACT_A_LEVEL, {31'd0, ca});
        apb_write(REG_CONTACT_B_LEVEL, {31'd0, cb});
        apb_write(REG_RESTORE_HOLD_POLLS, {24'd0, hold});
        apb_write(REG_UPS_PRESENT, {31'd0, ups});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random samples: restore polls with a chosen share, any pin now and then,
    // otherwise the alarm pins with random levels
    task automatic sample_burst(input int count, input int restore_pct, input int high_pm);
        int         k;
        int         r;
        logic [3:0] pin;
        logic       lvl;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(99);
            lvl = 1'($urandom_range(1));
            if (r < restore_pct) begin
                pin = PIN_RESTORE;
                lvl = ($urandom_range(999) < high_pm);
            end else if (r < restore_pct + 12) begin
                pin = 4'($urandom_range(15));
            end else begin
                case ($urandom_range(5))
                    0: pin = PIN_LASER;
                    1: pin = PIN_VOLT;
                    2: pin = PIN_AC;
                    3: pin = PIN_BATT;
                    4: pin = PIN_CA;
                    default: pin = PIN_CB;
                endcase
            end
            send_sample(pin, lvl);
        end
    endtask

    // stimulus
    initial begin
        send_idle_pct = 24;
        recv_idle_pct = 71;
        holds_asked   = 0;
        holds_done    = 0;
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, unused pins, every raise and clear
        send_sample(4'd0, 1'b1);
        send_sample(4'd15, 1'b1);
        send_sample(4'd6, 1'b0);
        send_sample(4'd10, 1'b1);
        send_sample(PIN_LASER, 1'b1);
        send_sample(PIN_LASER, 1'b1);
        send_sample(PIN_LASER, 1'b0);
        // volt low ignored while the ups is not valid
        send_sample(PIN_VOLT, 1'b1);
        send_sample(PIN_BATT, 1'b1);
        send_sample(PIN_BATT, 1'b0);
        // ups valid now: blink on raise, on at clear
        send_sample(PIN_VOLT, 1'b1);
        send_sample(PIN_VOLT, 1'b1);
        send_sample(PIN_VOLT, 1'b0);
        send_sample(PIN_AC, 1'b1);
        send_sample(PIN_AC, 1'b0);
        send_sample(PIN_CA, 1'b1);
        send_sample(PIN_CA, 1'b0);
        send_sample(PIN_CB, 1'b1);
        send_sample(PIN_CB, 1'b0);
        send_sample(PIN_RESTORE, 1'b0);
        send_sample(PIN_RESTORE, 1'b1);
        send_sample(PIN_BATT, 1'b1);
        send_sample(PIN_VOLT, 1'b1);
        send_sample(PIN_BATT, 1'b0);

        // zero hold threshold fires on every low poll, inverted alarm levels
        configure(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1);
        send_sample(PIN_RESTORE, 1'b0);
        send_sample(PIN_RESTORE, 1'b0);
        sample_burst(150, 30, 300);

        // long result hold-off while samples keep coming
        configure(1'b1, 1'b0, 1'b1, 1'b0, 8'd1, 1'b0);
        sample_burst(40, 25, 300);
        holds_asked = holds_asked + 1;
        sample_burst(110, 25, 300);

        // largest threshold: long runs of low restore polls
        send_idle_pct = 71;
        recv_idle_pct = 24;
        configure(1'b0, 1'b1, 1'b0, 1'b1, 8'd255, 1'b1);
        sample_burst(300, 90, 0);

        // sender pauses halfway until all results are in
        configure(1'b1, 1'b1, 1'b1, 1'b1, 8'd3, 1'b0);
        sample_burst(100, 30, 100);
        drain();
        sample_burst(100, 30, 100);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 8'($urandom_range(2, 12)), 1'($urandom_range(1)));
        sample_burst(200, 35, 80);
        configure(1'b0, 1'b1, 1'b1, 1'b0, 8'd5, 1'b1);
        sample_burst(150, 30, 150);

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("gpio_alarm_edge_monitor_top: match");
        else
            $display("gpio_alarm_edge_monitor_top: mismatch");
        $finish;
    end

endmodule
